/* hdl/sse_pkg.sv */
// Shared constants, command and result types for the sorted set engine.
package sse_pkg;

   localparam int CAPACITY    = 1024;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int KEY_W       = 16;
   localparam int KIND_W      = 2;
   localparam int ENTRY_W     = 11;
   localparam int RSP_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_QUERY  = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_DELETE = KIND_W'(2);

   typedef enum logic [1:0] {
      OP_QUERY,
      OP_INSERT,
      OP_DELETE,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
   } cmd_type;

   typedef struct packed {
      logic               success;
      logic               store_full;
      logic [ENTRY_W-1:0] entry_count;
   } result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
   } status_type;

endpackage

/* hdl/sse_front.sv */
// Front end: accepts request beats and decodes them into commands.
module sse_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sse_pkg::KIND_W-1:0]  kind,
   input  logic [sse_pkg::KEY_W-1:0]   key_value,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output sse_pkg::cmd_type            cmd
);

   logic             hold_valid_ff;
   logic             hold_valid_in;
   sse_pkg::cmd_type hold_cmd_ff;
   sse_pkg::cmd_type hold_cmd_in;
   sse_pkg::op_type  decoded_op;

   always_comb begin
      case (kind)
         sse_pkg::KIND_QUERY:  decoded_op = sse_pkg::OP_QUERY;
         sse_pkg::KIND_INSERT: decoded_op = sse_pkg::OP_INSERT;
         sse_pkg::KIND_DELETE: decoded_op = sse_pkg::OP_DELETE;
         default:              decoded_op = sse_pkg::OP_NOP;
      endcase
   end

   assign req_tready = !hold_valid_ff || cmd_ready;
   assign cmd_valid  = hold_valid_ff;
   assign cmd        = hold_cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff && !cmd_ready;
      hold_cmd_in   = hold_cmd_ff;
      if (req_tvalid && req_tready) begin
         hold_valid_in   = 1'b1;
         hold_cmd_in.op  = decoded_op;
         hold_cmd_in.key = key_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

/* hdl/sse_queue.sv */
// Short command queue between the front end and the executor.
module sse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sse_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sse_pkg::cmd_type pop_data
);

   sse_pkg::cmd_type              entries_ff [sse_pkg::QUEUE_DEPTH];
   logic [sse_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [sse_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [sse_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [sse_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [sse_pkg::QCNT_W-1:0]    fill_ff;
   logic [sse_pkg::QCNT_W-1:0]    fill_in;
   logic                          do_push;
   logic                          do_pop;

   assign push_ready = fill_ff != sse_pkg::QCNT_W'(sse_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sse_pkg::QPTR_W'(sse_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sse_pkg::QPTR_W'(sse_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/sse_back.sv */
// Executor: binary search over the sorted store, then an element shift for updates.
module sse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  sse_pkg::cmd_type     cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sse_pkg::result_type  rsp,
   output sse_pkg::status_type  status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_COMPARE,
      S_CHECK,
      S_MOVE
   } state_type;

   logic [sse_pkg::KEY_W-1:0]   store_mem [sse_pkg::CAPACITY];

   state_type                   state_ff, state_in;
   sse_pkg::op_type             op_ff, op_in;
   logic [sse_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [sse_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sse_pkg::COUNT_W-1:0] lo_ff, lo_in;
   logic [sse_pkg::COUNT_W-1:0] hi_ff, hi_in;
   logic [sse_pkg::COUNT_W-1:0] mid_ff, mid_in;
   logic [sse_pkg::COUNT_W-1:0] src_ff, src_in;
   logic [sse_pkg::COUNT_W-1:0] dst_ff, dst_in;
   logic [sse_pkg::COUNT_W-1:0] left_ff, left_in;
   logic                        pend_ff, pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sse_pkg::result_type         rsp_ff, rsp_in;
   logic [sse_pkg::KEY_W-1:0]   rd_data_ff;

   logic                        rd_en;
   logic [sse_pkg::ADDR_W-1:0]  rd_addr;
   logic                        wr_en;
   logic [sse_pkg::ADDR_W-1:0]  wr_addr;
   logic [sse_pkg::KEY_W-1:0]   wr_data;
   logic [sse_pkg::COUNT_W-1:0] mid;
   logic                        rsp_free;
   logic                        present;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && rsp_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign status.count = count_ff;
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign present = (lo_ff < count_ff) && (rd_data_ff == key_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = lo_ff[sse_pkg::ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = dst_ff[sse_pkg::ADDR_W-1:0];
      wr_data      = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && rsp_free) begin
               op_in  = cmd.op;
               key_in = cmd.key;
               lo_in  = '0;
               hi_in  = count_ff;
               if (cmd.op == sse_pkg::OP_NOP) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.success     = 1'b0;
                  rsp_in.store_full  = 1'b0;
                  rsp_in.entry_count = sse_pkg::ENTRY_W'(count_ff);
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            rd_en = 1'b1;
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[sse_pkg::ADDR_W-1:0];
               mid_in   = mid;
               state_in = S_COMPARE;
            end else begin
               // Search has converged: fetch the candidate at the insertion point.
               rd_addr  = lo_ff[sse_pkg::ADDR_W-1:0];
               state_in = S_CHECK;
            end
         end
         S_COMPARE: begin
            if (rd_data_ff < key_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_PROBE;
         end
         S_CHECK: begin
            rsp_in.success     = 1'b0;
            rsp_in.store_full  = 1'b0;
            rsp_in.entry_count = sse_pkg::ENTRY_W'(count_ff);
            pend_in            = 1'b0;
            case (op_ff)
               sse_pkg::OP_QUERY: begin
                  rsp_in.success = present;
                  rsp_valid_in   = 1'b1;
                  state_in       = S_IDLE;
               end
               sse_pkg::OP_INSERT: begin
                  if (present) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else if (count_ff == sse_pkg::COUNT_W'(sse_pkg::CAPACITY)) begin
                     rsp_in.store_full = 1'b1;
                     rsp_valid_in      = 1'b1;
                     state_in          = S_IDLE;
                  end else begin
                     // Shift the tail up by one, starting at the top entry.
                     src_in   = count_ff - 1'b1;
                     left_in  = count_ff - lo_ff;
                     state_in = S_MOVE;
                  end
               end
               sse_pkg::OP_DELETE: begin
                  if (!present) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     src_in   = lo_ff + 1'b1;
                     left_in  = count_ff - lo_ff - 1'b1;
                     state_in = S_MOVE;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_MOVE: begin
            // One read and one write per cycle; the write lands in the cycle after its read.
            pend_in = 1'b0;
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = src_ff[sse_pkg::ADDR_W-1:0];
               left_in = left_ff - 1'b1;
               pend_in = 1'b1;
               if (op_ff == sse_pkg::OP_INSERT) begin
                  src_in = src_ff - 1'b1;
                  dst_in = src_ff + 1'b1;
               end else begin
                  src_in = src_ff + 1'b1;
                  dst_in = src_ff - 1'b1;
               end
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff[sse_pkg::ADDR_W-1:0];
               wr_data = rd_data_ff;
            end else if (left_ff == '0) begin
               rsp_in.success    = 1'b1;
               rsp_in.store_full = 1'b0;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
               if (op_ff == sse_pkg::OP_INSERT) begin
                  wr_en              = 1'b1;
                  wr_addr            = lo_ff[sse_pkg::ADDR_W-1:0];
                  wr_data            = key_ff;
                  count_in           = count_ff + 1'b1;
                  rsp_in.entry_count = sse_pkg::ENTRY_W'(count_ff + 1'b1);
               end else begin
                  count_in           = count_ff - 1'b1;
                  rsp_in.entry_count = sse_pkg::ENTRY_W'(count_ff - 1'b1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

endmodule

/* hdl/sorted_set_engine.sv */
// Requests pass through the front register and the queue to the executor, which issues each
// command, runs at most ceil(log2(count+1)) binary-search probes, then a fetch and a check.
// Inserts and deletes then shift the tail with one read and one write per cycle.
// Throughput is one request at a time in the executor, bounded by the tail shift.
// Reset is synchronous and clears control and the count; store is not cleared.
module sorted_set_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key_value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] success, [1] store_full, [12:2] entry_count
);

   logic                cmd_valid;
   logic                cmd_ready;
   sse_pkg::cmd_type    front_cmd;
   logic                exec_valid;
   logic                exec_ready;
   sse_pkg::cmd_type    exec_cmd;
   sse_pkg::result_type result;
   sse_pkg::status_type status;

   sse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (req_tuser),
      .key_value  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (front_cmd)
   );

   sse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_data  (front_cmd),
      .pop_valid  (exec_valid),
      .pop_ready  (exec_ready),
      .pop_data   (exec_cmd)
   );

   sse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (exec_valid),
      .cmd_ready (exec_ready),
      .cmd       (exec_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result),
      .status    (status)
   );

   assign rsp_tdata = {
      (sse_pkg::RSP_DATA_W - sse_pkg::ENTRY_W - 2)'(0),
      result.entry_count,
      result.store_full,
      result.success
   };

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_full_not_success: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.store_full |-> !result.success)
      else $error("refused insert reported as success");

   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.store_full |->
         result.entry_count == sse_pkg::ENTRY_W'(sse_pkg::CAPACITY))
      else $error("store_full raised below capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      status.count != $past(status.count) |->
         (status.count == $past(status.count) + 1'b1) ||
         (status.count == $past(status.count) - 1'b1))
      else $error("entry count jumped by more than one");

endmodule
